// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CHK_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/fde_pkg.sv =====
// Shared types and codes of the frame buffer draw engine.
package fde_pkg;
	localparam int CW = 18;  // line coordinates, holds start + size - 1
	localparam int EW = 21;  // Bresenham deltas, error and doubled error
	localparam int RW = 9;   // screen size registers and dirty box edges

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [EW-1:0] err_t;
	typedef logic [RW-1:0]        box_t;

	localparam logic [2:0] CMD_SET_PIXEL = 3'd0;
	localparam logic [2:0] CMD_FILL      = 3'd1;
	localparam logic [2:0] CMD_LINE      = 3'd2;
	localparam logic [2:0] CMD_OUTLINE   = 3'd3;
	localparam logic [2:0] CMD_CLEAR     = 3'd4;
	localparam logic [2:0] CMD_PRESENT   = 3'd5;
	localparam logic [2:0] CMD_READ      = 3'd6;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;
endpackage

// ===== rtl/framebuffer_draw_engine_core.sv =====
// Frame buffer draw engine: RGB565 frame store, line/fill/clear commands, dirty box.
//
// Usage:
//  - Command channel (cmd_valid/cmd_stall) carries command, x_start, y_start,
//    x_end_or_width, y_end_or_height and color. A transfer happens when cmd_valid
//    is high and cmd_stall low. One command is worked on at a time.
//  - Response channel (rsp_valid/rsp_stall) returns one result per command: the
//    dirty box after the command (before clearing, for present) and pixel_value.
//    The result register holds while rsp_stall is high; the next command is
//    taken meanwhile and finishes once the register frees up.
//  - Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes screen width
//    (index 0) and height (index 1); always ready, write only while idle.
//  - Set pixel runs as a one-pixel line and outline as four lines; a line covers
//    major axis length + 1 pixels. One frame store port sets the pixel per cycle
//    rate of fill and clear; each on-screen line pixel is read, compared and
//    then written only if its color differs.
//  - After reset the frame store is swept to zero with cmd_stall high. The dirty
//    box starts as the full screen.
module framebuffer_draw_engine_core import fde_pkg::*; #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [8:0]         cfg_data,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  logic [2:0]         command,
	input  logic signed [15:0] x_start,
	input  logic signed [15:0] y_start,
	input  logic signed [15:0] x_end_or_width,
	input  logic signed [15:0] y_end_or_height,
	input  logic [15:0]        color,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic               dirty_valid,
	output logic [7:0]         dirty_x,
	output logic [7:0]         dirty_y,
	output logic [8:0]         dirty_w,
	output logic [8:0]         dirty_h,
	output logic [15:0]        pixel_value
);
	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int MAXW_C = (MAX_WIDTH > 511) ? 511 : MAX_WIDTH;
	localparam int MAXH_C = (MAX_HEIGHT > 511) ? 511 : MAX_HEIGHT;
	localparam int RSTW_C = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
	localparam int RSTH_C = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;
	localparam box_t MAXW_B = box_t'(MAXW_C);
	localparam box_t MAXH_B = box_t'(MAXH_C);
	localparam box_t RSTW_B = box_t'(RSTW_C);
	localparam box_t RSTH_B = box_t'(RSTH_C);

	localparam logic [3:0] ST_MEMCLR = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_LINIT  = 4'd2;
	localparam logic [3:0] ST_LPIX   = 4'd3;
	localparam logic [3:0] ST_LRD    = 4'd4;
	localparam logic [3:0] ST_LCMP   = 4'd5;
	localparam logic [3:0] ST_LSTEP  = 4'd6;
	localparam logic [3:0] ST_FSET   = 4'd7;
	localparam logic [3:0] ST_FADDR  = 4'd8;
	localparam logic [3:0] ST_FRUN   = 4'd9;
	localparam logic [3:0] ST_CSIZE  = 4'd10;
	localparam logic [3:0] ST_CRUN   = 4'd11;
	localparam logic [3:0] ST_RADDR  = 4'd12;
	localparam logic [3:0] ST_RRD    = 4'd13;
	localparam logic [3:0] ST_RCAP   = 4'd14;
	localparam logic [3:0] ST_DONE   = 4'd15;

	function automatic box_t clamp_dim(box_t v, box_t m);
		if (v == '0)
			return box_t'(1);
		else if (v > m)
			return m;
		else
			return v;
	endfunction

	function automatic logic on_scr(coord_t x, coord_t y, box_t w, box_t h);
		return (x >= 0) && (y >= 0) && (x < coord_t'(w)) && (y < coord_t'(h));
	endfunction

	// Only called for on-screen points, so y*w + x stays below DEPTH.
	function automatic logic [AW-1:0] pix_addr(coord_t x, coord_t y, box_t w);
		logic [CW-1:0]    xu;
		logic [CW-1:0]    yu;
		logic [CW+RW-1:0] p;
		xu = x;
		yu = y;
		p  = yu * w;
		return AW'(p + (CW+RW)'(xu));
	endfunction

	logic [15:0] mem [DEPTH];
	logic [15:0] rd_data_q;
	logic        we;
	logic [AW-1:0] wa;
	logic [15:0]   wd;

	logic [3:0]  state_q;
	box_t        width_q, height_q, effw, effh;
	logic [2:0]  cmd_q;
	logic signed [15:0] xs_q, ys_q, xe_q, ye_q;
	logic [15:0] color_q;
	logic [1:0]  line_idx_q;
	coord_t      x_q, y_q, x1_q, y1_q;
	err_t        dx_q, dy_q, err_q;
	logic        sx_neg_q, sy_neg_q;
	logic [AW-1:0] addr_q, row_q;
	logic [AW:0]   cnt_q, n_q;
	box_t        fl_q, fr_q, fb_q, fx_q, fy_q;
	logic [15:0] pix_q;
	logic        flag_q;
	box_t        left_q, top_q, right_q, bottom_q;
	logic        rsp_valid_q;
	logic        out_dv_q;
	logic [7:0]  out_x_q, out_y_q;
	logic [8:0]  out_w_q, out_h_q;
	logic [15:0] out_pix_q;

	// line setup
	coord_t xa, ya, xb, yb, p0x, p0y, p1x, p1y;
	err_t   ddx, ddy, adx, ady;
	// line step
	err_t   e2, nerr;
	coord_t nx, ny;
	logic   line_end;
	// fill setup
	coord_t f_l, f_t, f_r, f_b, f_xr, f_yb;
	logic   f_some;
	// dirty box update
	logic   mark_en;
	box_t   ml, mt, mr, mb;
	logic   take_done;

	assign effw = clamp_dim(width_q, MAXW_B);
	assign effh = clamp_dim(height_q, MAXH_B);

	assign cfg_ready   = 1'b1;
	assign cmd_stall   = (state_q != ST_IDLE);
	assign rsp_valid   = rsp_valid_q;
	assign dirty_valid = out_dv_q;
	assign dirty_x     = out_x_q;
	assign dirty_y     = out_y_q;
	assign dirty_w     = out_w_q;
	assign dirty_h     = out_h_q;
	assign pixel_value = out_pix_q;

	always_comb begin
		xa = coord_t'(xs_q);
		ya = coord_t'(ys_q);
		xb = xa + coord_t'(xe_q) - coord_t'(1);
		yb = ya + coord_t'(ye_q) - coord_t'(1);
		p0x = xa;
		p0y = ya;
		p1x = xa;
		p1y = ya;
		case (cmd_q)
			CMD_LINE: begin
				p1x = coord_t'(xe_q);
				p1y = coord_t'(ye_q);
			end
			CMD_OUTLINE: begin
				case (line_idx_q)
					2'd0: begin
						p1x = xb;
					end
					2'd1: begin
						p0y = yb; p1x = xb; p1y = yb;
					end
					2'd2: begin
						p1y = yb;
					end
					default: begin
						p0x = xb; p1x = xb; p1y = yb;
					end
				endcase
			end
			default: ;
		endcase
		ddx = err_t'(p1x) - err_t'(p0x);
		ddy = err_t'(p1y) - err_t'(p0y);
		adx = (ddx < 0) ? -ddx : ddx;
		ady = (ddy < 0) ? -ddy : ddy;
	end

	always_comb begin
		e2   = err_q <<< 1;
		nerr = err_q;
		nx   = x_q;
		ny   = y_q;
		if (e2 >= dy_q) begin
			nerr = nerr + dy_q;
			nx   = sx_neg_q ? x_q - coord_t'(1) : x_q + coord_t'(1);
		end
		if (e2 <= dx_q) begin
			nerr = nerr + dx_q;
			ny   = sy_neg_q ? y_q - coord_t'(1) : y_q + coord_t'(1);
		end
		line_end = (x_q == x1_q) && (y_q == y1_q);
	end

	always_comb begin
		f_xr   = xa + coord_t'(xe_q);
		f_yb   = ya + coord_t'(ye_q);
		f_l    = (xa < 0) ? '0 : xa;
		f_t    = (ya < 0) ? '0 : ya;
		f_r    = (f_xr > coord_t'(effw)) ? coord_t'(effw) : f_xr;
		f_b    = (f_yb > coord_t'(effh)) ? coord_t'(effh) : f_yb;
		f_some = (f_l < f_r) && (f_t < f_b);
	end

	always_comb begin
		we = 1'b0;
		wa = addr_q;
		wd = color_q;
		mark_en = 1'b0;
		ml = '0;
		mt = '0;
		mr = '0;
		mb = '0;
		case (state_q)
			ST_MEMCLR: begin
				we = 1'b1;
				wa = cnt_q[AW-1:0];
				wd = '0;
			end
			ST_LCMP: begin
				we      = (rd_data_q != color_q);
				mark_en = we;
				ml      = x_q[RW-1:0];
				mt      = y_q[RW-1:0];
				mr      = x_q[RW-1:0] + box_t'(1);
				mb      = y_q[RW-1:0] + box_t'(1);
			end
			ST_FSET: begin
				mark_en = f_some;
				ml      = f_l[RW-1:0];
				mt      = f_t[RW-1:0];
				mr      = f_r[RW-1:0];
				mb      = f_b[RW-1:0];
			end
			ST_FRUN: begin
				we = 1'b1;
			end
			ST_CSIZE: begin
				mark_en = 1'b1;
				mr      = effw;
				mb      = effh;
			end
			ST_CRUN: begin
				we = 1'b1;
				wa = cnt_q[AW-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		rd_data_q <= mem[addr_q];
	end

	assign take_done = (state_q == ST_DONE) && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_MEMCLR;
			cnt_q       <= '0;
			width_q     <= box_t'(256);
			height_q    <= box_t'(256);
			flag_q      <= 1'b1;
			left_q      <= '0;
			top_q       <= '0;
			right_q     <= RSTW_B;
			bottom_q    <= RSTH_B;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_WIDTH:  width_q  <= cfg_data;
					REG_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
			end

			if (mark_en) begin
				if (!flag_q) begin
					flag_q   <= 1'b1;
					left_q   <= ml;
					top_q    <= mt;
					right_q  <= mr;
					bottom_q <= mb;
				end else begin
					left_q   <= (ml < left_q) ? ml : left_q;
					top_q    <= (mt < top_q) ? mt : top_q;
					right_q  <= (mr > right_q) ? mr : right_q;
					bottom_q <= (mb > bottom_q) ? mb : bottom_q;
				end
			end

			if (take_done)
				rsp_valid_q <= 1'b1;
			else if (rsp_valid_q && !rsp_stall)
				rsp_valid_q <= 1'b0;

			case (state_q)
				ST_MEMCLR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == (AW+1)'(DEPTH - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						cmd_q      <= command;
						xs_q       <= x_start;
						ys_q       <= y_start;
						xe_q       <= x_end_or_width;
						ye_q       <= y_end_or_height;
						color_q    <= color;
						pix_q      <= '0;
						line_idx_q <= '0;
						case (command)
							CMD_SET_PIXEL, CMD_LINE, CMD_OUTLINE: state_q <= ST_LINIT;
							CMD_FILL:  state_q <= ST_FSET;
							CMD_CLEAR: state_q <= ST_CSIZE;
							CMD_READ:  state_q <= ST_RADDR;
							default:   state_q <= ST_DONE;
						endcase
					end
				end
				ST_LINIT: begin
					x_q      <= p0x;
					y_q      <= p0y;
					x1_q     <= p1x;
					y1_q     <= p1y;
					dx_q     <= adx;
					dy_q     <= -ady;
					err_q    <= adx - ady;
					sx_neg_q <= !(p0x < p1x);
					sy_neg_q <= !(p0y < p1y);
					state_q  <= ST_LPIX;
				end
				ST_LPIX: begin
					if (on_scr(x_q, y_q, effw, effh)) begin
						addr_q  <= pix_addr(x_q, y_q, effw);
						state_q <= ST_LRD;
					end else begin
						state_q <= ST_LSTEP;
					end
				end
				ST_LRD: state_q <= ST_LCMP;
				ST_LCMP: state_q <= ST_LSTEP;
				ST_LSTEP: begin
					if (line_end) begin
						if (cmd_q == CMD_OUTLINE && line_idx_q != 2'd3) begin
							line_idx_q <= line_idx_q + 1'b1;
							state_q    <= ST_LINIT;
						end else begin
							state_q <= ST_DONE;
						end
					end else begin
						x_q     <= nx;
						y_q     <= ny;
						err_q   <= nerr;
						state_q <= ST_LPIX;
					end
				end
				ST_FSET: begin
					fl_q <= f_l[RW-1:0];
					fr_q <= f_r[RW-1:0];
					fb_q <= f_b[RW-1:0];
					fx_q <= f_l[RW-1:0];
					fy_q <= f_t[RW-1:0];
					state_q <= f_some ? ST_FADDR : ST_DONE;
				end
				ST_FADDR: begin
					addr_q  <= pix_addr(coord_t'(fx_q), coord_t'(fy_q), effw);
					row_q   <= pix_addr(coord_t'(fx_q), coord_t'(fy_q), effw);
					state_q <= ST_FRUN;
				end
				ST_FRUN: begin
					if (fx_q + box_t'(1) == fr_q) begin
						if (fy_q + box_t'(1) == fb_q) begin
							state_q <= ST_DONE;
						end else begin
							fy_q   <= fy_q + box_t'(1);
							fx_q   <= fl_q;
							addr_q <= row_q + AW'(effw);
							row_q  <= row_q + AW'(effw);
						end
					end else begin
						fx_q   <= fx_q + box_t'(1);
						addr_q <= addr_q + 1'b1;
					end
				end
				ST_CSIZE: begin
					n_q     <= (AW+1)'(effw * effh);
					cnt_q   <= '0;
					state_q <= ST_CRUN;
				end
				ST_CRUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q + 1'b1 == n_q)
						state_q <= ST_DONE;
				end
				ST_RADDR: begin
					if (on_scr(xa, ya, effw, effh)) begin
						addr_q  <= pix_addr(xa, ya, effw);
						state_q <= ST_RRD;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_RRD: state_q <= ST_RCAP;
				ST_RCAP: begin
					pix_q   <= rd_data_q;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (take_done) begin
						if (cmd_q == CMD_PRESENT)
							flag_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result payload, loaded only when the result register is free
	always_ff @(posedge clk) begin
		if (take_done) begin
			out_dv_q  <= flag_q;
			out_x_q   <= flag_q ? left_q[7:0] : 8'd0;
			out_y_q   <= flag_q ? top_q[7:0] : 8'd0;
			out_w_q   <= flag_q ? 9'(right_q - left_q) : 9'd0;
			out_h_q   <= flag_q ? 9'(bottom_q - top_q) : 9'd0;
			out_pix_q <= pix_q;
		end
	end
endmodule

// ===== rtl/fde_checker.sv =====
// Port-level checks of the draw engine, bound to the top level.
`include "assert_macros.svh"
module fde_checker import fde_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       cmd_valid,
	input logic       cmd_stall,
	input logic       rsp_valid,
	input logic       rsp_stall,
	input logic       dirty_valid,
	input logic [7:0] dirty_x,
	input logic [7:0] dirty_y,
	input logic [8:0] dirty_w,
	input logic [8:0] dirty_h
);
	// a stalled response stays offered
	`CHK_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid, "response dropped")
	// no box pending means all box fields read zero
	`CHK_NOW(a_empty_box, clk, arst_n, rsp_valid && !dirty_valid,
		dirty_x == 8'd0 && dirty_y == 8'd0 && dirty_w == 9'd0 && dirty_h == 9'd0,
		"empty box not zero")
	// a pending box always covers at least one pixel
	`CHK_NOW(a_box_size, clk, arst_n, rsp_valid && dirty_valid,
		dirty_w != 9'd0 && dirty_h != 9'd0, "dirty box of zero size")
	// one command at a time: busy right after a command transfer
	`CHK_NEXT(a_busy, clk, arst_n, cmd_valid && !cmd_stall, cmd_stall, "second command taken")
endmodule

bind framebuffer_draw_engine_core fde_checker u_fde_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cmd_valid   (cmd_valid),
	.cmd_stall   (cmd_stall),
	.rsp_valid   (rsp_valid),
	.rsp_stall   (rsp_stall),
	.dirty_valid (dirty_valid),
	.dirty_x     (dirty_x),
	.dirty_y     (dirty_y),
	.dirty_w     (dirty_w),
	.dirty_h     (dirty_h)
);

// ===== tb/tb.sv =====
// Self-checking testbench for the frame buffer draw engine core.
module tb;
	import fde_pkg::*;

	localparam logic [2:0] CMD_NOP = 3'd7;  // unused code, reports the box only
	localparam int FB_DEPTH = 65536;
	localparam int MAX_DIM = 256;
	localparam longint CYCLE_LIMIT = 12000000;

	typedef struct packed {
		logic [2:0]         cmd;
		logic signed [15:0] xs;
		logic signed [15:0] ys;
		logic signed [15:0] xe;
		logic signed [15:0] ye;
		logic [15:0]        col;
	} draw_cmd_t;

	typedef struct packed {
		logic        dv;
		logic [7:0]  dx;
		logic [7:0]  dy;
		logic [8:0]  dw;
		logic [8:0]  dh;
		logic [15:0] pix;
	} box_rsp_t;

	logic clk, arst_n;
	logic cfg_valid, cfg_ready, cfg_index;
	logic [8:0] cfg_data;
	logic cmd_valid, cmd_stall;
	logic [2:0] command;
	logic signed [15:0] x_start, y_start, x_end_or_width, y_end_or_height;
	logic [15:0] color;
	logic rsp_valid, rsp_stall;
	logic dirty_valid;
	logic [7:0] dirty_x, dirty_y;
	logic [8:0] dirty_w, dirty_h;
	logic [15:0] pixel_value;

	framebuffer_draw_engine_core DUT (.*);

	// predictor state
	logic [15:0] pix_mem [FB_DEPTH];
	logic [8:0] scr_w_reg, scr_h_reg;
	bit box_flag;
	int box_l, box_t, box_r, box_b;

	draw_cmd_t pending_cmds[$];
	box_rsp_t  expected_boxes[$];
	int snd_idle_pct, rcv_idle_pct;
	int n_errors, n_cmds, n_rsps, n_clears;
	longint n_cycles;

	function automatic int eff_w();
		if (scr_w_reg < 1) return 1;
		if (scr_w_reg > MAX_DIM) return MAX_DIM;
		return int'(scr_w_reg);
	endfunction

	function automatic int eff_h();
		if (scr_h_reg < 1) return 1;
		if (scr_h_reg > MAX_DIM) return MAX_DIM;
		return int'(scr_h_reg);
	endfunction

	function automatic void grow_box(int x, int y, int w, int h);
		int l, t, r, b;
		l = (x > 0) ? x : 0;
		t = (y > 0) ? y : 0;
		r = (x + w < eff_w()) ? x + w : eff_w();
		b = (y + h < eff_h()) ? y + h : eff_h();
		if (l >= r || t >= b) return;
		if (!box_flag) begin
			box_flag = 1;
			box_l = l; box_t = t; box_r = r; box_b = b;
			return;
		end
		if (l < box_l) box_l = l;
		if (t < box_t) box_t = t;
		if (r > box_r) box_r = r;
		if (b > box_b) box_b = b;
	endfunction

	function automatic bit on_screen(int x, int y);
		return x >= 0 && y >= 0 && x < eff_w() && y < eff_h();
	endfunction

	function automatic void plot(int x, int y, logic [15:0] c);
		int a;
		if (!on_screen(x, y)) return;
		a = (y * eff_w() + x) % FB_DEPTH;
		if (pix_mem[a] == c) return;
		pix_mem[a] = c;
		grow_box(x, y, 1, 1);
	endfunction

	function automatic void fill_rect(int x, int y, int w, int h, logic [15:0] c);
		int l, t, r, b;
		l = (x > 0) ? x : 0;
		t = (y > 0) ? y : 0;
		r = (x + w < eff_w()) ? x + w : eff_w();
		b = (y + h < eff_h()) ? y + h : eff_h();
		for (int j = t; j < b; j++)
			for (int i = l; i < r; i++)
				pix_mem[(j * eff_w() + i) % FB_DEPTH] = c;
		grow_box(l, t, r - l, b - t);
	endfunction

	function automatic void draw_line(int x0, int y0, int x1, int y1, logic [15:0] c);
		int dx, dy, sx, sy, err, e2;
		dx = (x1 > x0) ? x1 - x0 : x0 - x1;
		dy = (y1 > y0) ? y0 - y1 : y1 - y0;
		sx = (x0 < x1) ? 1 : -1;
		sy = (y0 < y1) ? 1 : -1;
		err = dx + dy;
		forever begin
			plot(x0, y0, c);
			if (x0 == x1 && y0 == y1) break;
			e2 = 2 * err;
			if (e2 >= dy) begin
				err += dy; x0 += sx;
			end
			if (e2 <= dx) begin
				err += dx; y0 += sy;
			end
		end
	endfunction

	function automatic box_rsp_t predict_box(draw_cmd_t it);
		box_rsp_t r;
		int xs, ys, xe, ye, n;
		logic [15:0] pix;
		xs = it.xs; ys = it.ys; xe = it.xe; ye = it.ye;
		pix = '0;
		case (it.cmd)
			CMD_SET_PIXEL: plot(xs, ys, it.col);
			CMD_FILL:      fill_rect(xs, ys, xe, ye, it.col);
			CMD_LINE:      draw_line(xs, ys, xe, ye, it.col);
			CMD_OUTLINE: begin
				draw_line(xs, ys, xs + xe - 1, ys, it.col);
				draw_line(xs, ys + ye - 1, xs + xe - 1, ys + ye - 1, it.col);
				draw_line(xs, ys, xs, ys + ye - 1, it.col);
				draw_line(xs + xe - 1, ys, xs + xe - 1, ys + ye - 1, it.col);
			end
			CMD_CLEAR: begin
				n = eff_w() * eff_h();
				for (int k = 0; k < n && k < FB_DEPTH; k++) pix_mem[k] = it.col;
				grow_box(0, 0, eff_w(), eff_h());
			end
			CMD_READ: if (on_screen(xs, ys)) pix = pix_mem[(ys * eff_w() + xs) % FB_DEPTH];
			default: ;
		endcase
		r.dv  = box_flag;
		r.dx  = box_flag ? box_l[7:0] : '0;
		r.dy  = box_flag ? box_t[7:0] : '0;
		r.dw  = box_flag ? 9'(box_r - box_l) : '0;
		r.dh  = box_flag ? 9'(box_b - box_t) : '0;
		r.pix = pix;
		if (it.cmd == CMD_PRESENT) box_flag = 0;
		return r;
	endfunction

	task automatic check_field(string name, int exp_v, int act_v);
		if (exp_v != act_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
			n_errors++;
		end
	endtask

	function automatic draw_cmd_t mk(logic [2:0] c, int xs, int ys, int xe, int ye,
			logic [15:0] col);
		draw_cmd_t it;
		it.cmd = c; it.xs = 16'(xs); it.ys = 16'(ys);
		it.xe = 16'(xe); it.ye = 16'(ye); it.col = col;
		return it;
	endfunction

	// coordinate around the visible area, sometimes anywhere in 16 bits
	function automatic int rnd_coord(int lim, bit wide);
		if (wide && $urandom_range(7) == 0) return int'($signed(16'($urandom)));
		return int'($urandom_range(lim + 24)) - 12;
	endfunction

	function automatic int rnd_size(bit wide);
		if (wide && $urandom_range(7) == 0) return int'($signed(16'($urandom)));
		return int'($urandom_range(44)) - 4;
	endfunction

	function automatic draw_cmd_t rnd_cmd();
		int w, h, sel;
		bit cheap;
		logic [15:0] col;
		w = eff_w(); h = eff_h();
		cheap = (w * h) <= 4096;
		col = ($urandom_range(3) == 0) ? 16'($urandom_range(3)) : 16'($urandom);
		sel = $urandom_range(99);
		if (sel < 22) return mk(CMD_SET_PIXEL, rnd_coord(w, 1), rnd_coord(h, 1),
			int'($signed(16'($urandom))), int'($signed(16'($urandom))), col);
		if (sel < 36) return mk(CMD_FILL, rnd_coord(w, 1), rnd_coord(h, 1),
			rnd_size(cheap), rnd_size(cheap), col);
		if (sel < 56) return mk(CMD_LINE, rnd_coord(w, 0), rnd_coord(h, 0),
			rnd_coord(w, 0), rnd_coord(h, 0), col);
		if (sel < 66) return mk(CMD_OUTLINE, rnd_coord(w, 0), rnd_coord(h, 0),
			rnd_size(0), rnd_size(0), col);
		if (sel < 70 && (cheap ? 1'b1 : $urandom_range(60) == 0))
			return mk(CMD_CLEAR, 0, 0, 0, 0, col);
		if (sel < 80) return mk(CMD_PRESENT, 0, 0, 0, 0, col);
		if (sel < 97) return mk(CMD_READ, rnd_coord(w, 1), rnd_coord(h, 1), 0, 0, col);
		return mk(CMD_NOP, rnd_coord(w, 1), rnd_coord(h, 1), 0, 0, col);
	endfunction

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// command driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 0;
			command <= '0; x_start <= '0; y_start <= '0;
			x_end_or_width <= '0; y_end_or_height <= '0; color <= '0;
		end else begin
			if (cmd_valid && !cmd_stall) begin
				expected_boxes.push_back(predict_box({command, x_start, y_start,
					x_end_or_width, y_end_or_height, color}));
				n_cmds++;
				if (command == CMD_CLEAR) n_clears++;
			end
			if (!cmd_valid || !cmd_stall) begin
				if (pending_cmds.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
					draw_cmd_t it;
					it = pending_cmds.pop_front();
					command <= it.cmd; x_start <= it.xs; y_start <= it.ys;
					x_end_or_width <= it.xe; y_end_or_height <= it.ye; color <= it.col;
					cmd_valid <= 1;
				end else begin
					cmd_valid <= 0;
				end
			end
		end
	end

	// response monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				n_rsps++;
				if (expected_boxes.size() == 0) begin
					$error("unexpected response transfer");
					n_errors++;
				end else begin
					box_rsp_t e;
					e = expected_boxes.pop_front();
					check_field("dirty_valid", e.dv, dirty_valid);
					check_field("dirty_x", e.dx, dirty_x);
					check_field("dirty_y", e.dy, dirty_y);
					check_field("dirty_w", e.dw, dirty_w);
					check_field("dirty_h", e.dh, dirty_h);
					check_field("pixel_value", e.pix, pixel_value);
				end
			end
			rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
		end
	end

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", n_cycles);
			$display("FAIL");
			$finish;
		end
	end

	task automatic write_reg(logic idx, logic [8:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == REG_WIDTH) scr_w_reg = val;
		else scr_h_reg = val;
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic drain();
		@(posedge clk);
		while (pending_cmds.size() > 0 || cmd_valid || expected_boxes.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		int widths[6], heights[6];
		widths  = '{17, 0, 511, 64, 256, 1};
		heights = '{9, 0, 300, 40, 1, 256};
		n_errors = 0; n_cmds = 0; n_rsps = 0; n_clears = 0; n_cycles = 0;
		snd_idle_pct = 0; rcv_idle_pct = 0;
		foreach (pix_mem[i]) pix_mem[i] = '0;
		scr_w_reg = 256; scr_h_reg = 256;
		box_flag = 1; box_l = 0; box_t = 0; box_r = 256; box_b = 256;
		cfg_valid = 0; cfg_index = 0; cfg_data = '0;
		arst_n = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		write_reg(REG_WIDTH, 9'd256);
		write_reg(REG_HEIGHT, 9'd256);
		// directed part at full screen
		pending_cmds.push_back(mk(CMD_PRESENT, 0, 0, 0, 0, 16'h0000));
		pending_cmds.push_back(mk(CMD_PRESENT, 0, 0, 0, 0, 16'h0000));
		pending_cmds.push_back(mk(CMD_SET_PIXEL, 0, 0, 0, 0, 16'hFFFF));
		pending_cmds.push_back(mk(CMD_SET_PIXEL, 0, 0, -1, 32767, 16'hFFFF));
		pending_cmds.push_back(mk(CMD_SET_PIXEL, -1, 0, 0, 0, 16'h1234));
		pending_cmds.push_back(mk(CMD_SET_PIXEL, 32767, -32768, 0, 0, 16'h5555));
		pending_cmds.push_back(mk(CMD_SET_PIXEL, 255, 255, 0, 0, 16'hAAAA));
		pending_cmds.push_back(mk(CMD_READ, 0, 0, 0, 0, 16'h0000));
		pending_cmds.push_back(mk(CMD_READ, 256, -1, 0, 0, 16'h0000));
		pending_cmds.push_back(mk(CMD_PRESENT, 0, 0, 0, 0, 16'h0000));
		pending_cmds.push_back(mk(CMD_FILL, 10, 10, 0, 5, 16'h00FF));
		pending_cmds.push_back(mk(CMD_FILL, 10, 10, -32768, 5, 16'h00FF));
		pending_cmds.push_back(mk(CMD_FILL, -32768, -32768, 32767, 32767, 16'h00FF));
		pending_cmds.push_back(mk(CMD_FILL, 250, 250, 32767, 32767, 16'hF800));
		pending_cmds.push_back(mk(CMD_FILL, 250, 250, 3, 3, 16'hF800));
		pending_cmds.push_back(mk(CMD_LINE, 3, 7, 60, 7, 16'h07E0));
		pending_cmds.push_back(mk(CMD_LINE, 40, 90, 40, 20, 16'h001F));
		pending_cmds.push_back(mk(CMD_LINE, 100, 5, 90, 60, 16'hBEEF));
		pending_cmds.push_back(mk(CMD_LINE, -5, -5, 20, 300, 16'h1357));
		pending_cmds.push_back(mk(CMD_OUTLINE, 5, 5, 10, 6, 16'h2468));
		pending_cmds.push_back(mk(CMD_OUTLINE, 5, 5, 0, 0, 16'h0F0F));
		pending_cmds.push_back(mk(CMD_OUTLINE, 20, 20, -3, -4, 16'hF0F0));
		pending_cmds.push_back(mk(CMD_NOP, 1, 2, 3, 4, 16'h7777));
		pending_cmds.push_back(mk(CMD_CLEAR, 0, 0, 0, 0, 16'h8000));
		pending_cmds.push_back(mk(CMD_READ, 128, 64, 0, 0, 16'h0000));
		drain();

		for (int p = 0; p < 6; p++) begin
			write_reg(REG_WIDTH, 9'(widths[p]));
			write_reg(REG_HEIGHT, 9'(heights[p]));
			case (p % 4)
				0: begin snd_idle_pct = 0;  rcv_idle_pct = 0;  end
				1: begin snd_idle_pct = 71; rcv_idle_pct = 0;  end
				2: begin snd_idle_pct = 0;  rcv_idle_pct = 71; end
				default: begin snd_idle_pct = 35; rcv_idle_pct = 35; end
			endcase
			for (int i = 0; i < 205; i++) pending_cmds.push_back(rnd_cmd());
			drain();
			snd_idle_pct = 0; rcv_idle_pct = 0;
		end

		$display("%0d commands sent, %0d responses checked, %0d clears, %0d cycles",
			n_cmds, n_rsps, n_clears, n_cycles);
		$display("covered 7 screen settings incl. clamped sizes, 4 idle/stall modes");
		if (n_errors == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/fde_pkg.sv
rtl/framebuffer_draw_engine_core.sv
rtl/fde_checker.sv
tb/tb.sv
